>>> sv/lkt_pkg.sv
// Package for the linear key table: sizes, action and state codes, the record
// and result layouts and the key text normalization function.
// No dependencies; imported by linear_key_table_core.
package lkt_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int PAYLOAD_BITS = 32;
  localparam int TEXT_W       = 64;
  localparam int MOD_W        = 16;
  localparam int OUT_PAY_W    = 32;

  typedef enum logic [2:0] {
    ACT_SELECT = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_UPDATE = 3'd3,
    ACT_PACK   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [TEXT_W-1:0]       text;
    logic [MOD_W-1:0]        kmod;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    deleted;
  } record_t;

  typedef struct packed {
    logic            found;
    logic [IDX_W-1:0] slot;
    record_t         rec;
    logic            full;
  } result_t;

  // A text ends at its first zero byte; clear everything after it so that
  // two texts can be compared as plain words.
  function automatic logic [TEXT_W-1:0] norm_text(input logic [TEXT_W-1:0] t);
    logic [TEXT_W-1:0] r;
    logic              ended;
    r     = t;
    ended = 1'b0;
    for (int b = 0; b < TEXT_W / 8; b++) begin
      if (t[8*b +: 8] == 8'h00) ended = 1'b1;
      if (ended) r[8*b +: 8] = 8'h00;
    end
    return r;
  endfunction

endpackage

>>> sv/linear_key_table_core.sv
// Linear key table: unsorted record table with lazy deletion, held in one
// synchronous record memory and scanned one entry per cycle. Uses lkt_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  in      | in_valid / in_ready     | action, key_text, key_mod, new_key_text,
//          |                         | new_key_mod, new_payload
//  out     | out_valid / out_ready   | found, slot, out_key_text, out_key_mod,
//          |                         | out_payload, out_deleted, table_full, used_count
//
// An operation scans k entries, at most the used count; the single read port
// of the record memory sets the scan at one entry per cycle. Select, delete
// and update stop at the first match from the top; insert stops at the first
// free slot. Reset clears the state, the used count and out_valid; the memory
// is not cleared, as no entry at or above the count is ever read. A new
// transfer is taken in idle while the previous result may still wait; the
// last step of an operation waits until the result register is free.
module linear_key_table_core
  import lkt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           action,
  input  logic [TEXT_W-1:0]    key_text,
  input  logic [MOD_W-1:0]     key_mod,
  input  logic [TEXT_W-1:0]    new_key_text,
  input  logic [MOD_W-1:0]     new_key_mod,
  input  logic [OUT_PAY_W-1:0] new_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 found,
  output logic [IDX_W-1:0]     slot,
  output logic [TEXT_W-1:0]    out_key_text,
  output logic [MOD_W-1:0]     out_key_mod,
  output logic [OUT_PAY_W-1:0] out_payload,
  output logic                 out_deleted,
  output logic                 table_full,
  output logic [CNT_W-1:0]     used_count
);

  state_t            state, state_next;
  action_t           act;
  logic [TEXT_W-1:0] key_norm;
  logic [MOD_W-1:0]  kmod;
  record_t           new_rec;
  logic [IDX_W-1:0]  cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  count, count_next;

  record_t           mem [TABLE_DEPTH];
  record_t           rdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  record_t           wr_data;

  logic              done;
  result_t           res;
  logic              out_free;
  logic              hit;
  logic              slot_free;
  logic              last_up;
  logic [IDX_W-1:0]  idx_dn, idx_up, cnt_m1;

  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign hit       = (norm_text(rdata.text) == key_norm) && (rdata.kmod == kmod);
  assign slot_free = (rdata.text[7:0] == 8'h00) || rdata.deleted;
  assign last_up   = ({1'b0, cmp_idx} + CNT_W'(1)) == count;
  assign idx_dn    = cmp_idx - IDX_W'(1);
  assign idx_up    = cmp_idx + IDX_W'(1);
  assign cnt_m1    = IDX_W'(count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    wr_ptr  <= wr_ptr_next;
    if (in_valid && in_ready) begin
      act      <= action_t'(action);
      key_norm <= norm_text(key_text);
      kmod     <= key_mod;
      new_rec  <= '{text: new_key_text, kmod: new_key_mod,
                    payload: PAYLOAD_BITS'(new_payload), deleted: 1'b0};
    end
  end

  always_comb begin
    state_next   = state;
    cmp_idx_next = cmp_idx;
    wr_ptr_next  = wr_ptr;
    count_next   = count;
    rd_en        = 1'b0;
    rd_addr      = cmp_idx;
    wr_en        = 1'b0;
    wr_addr      = cmp_idx;
    wr_data      = rdata;
    done         = 1'b0;
    res          = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end

      ST_START: begin
        case (act) inside
          ACT_SELECT, ACT_DELETE, ACT_UPDATE: begin
            if (count == '0) begin
              done = out_free;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = cnt_m1;
              cmp_idx_next = cnt_m1;
              state_next   = ST_SCAN;
            end
          end
          ACT_INSERT: begin
            if (count == '0) begin
              if (out_free) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_rec;
                count_next = CNT_W'(1);
                res.found  = 1'b1;
                res.rec    = new_rec;
                done       = 1'b1;
              end
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              cmp_idx_next = '0;
              state_next   = ST_SCAN;
            end
          end
          ACT_PACK: begin
            if (count == '0) begin
              done = out_free;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              cmp_idx_next = '0;
              wr_ptr_next  = '0;
              state_next   = ST_SCAN;
            end
          end
          default: begin
            done = out_free;
          end
        endcase
      end

      ST_SCAN: begin
        case (act) inside
          ACT_SELECT, ACT_DELETE, ACT_UPDATE: begin
            if (hit) begin
              if (out_free) begin
                res.found = 1'b1;
                res.slot  = cmp_idx;
                res.rec   = rdata;
                if (act == ACT_DELETE) begin
                  res.rec.deleted = 1'b1;
                  wr_en           = 1'b1;
                  wr_data         = res.rec;
                end else if (act == ACT_UPDATE) begin
                  res.rec = new_rec;
                  wr_en   = 1'b1;
                  wr_data = new_rec;
                end
                done = 1'b1;
              end
            end else if (cmp_idx == '0) begin
              done = out_free;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = idx_dn;
              cmp_idx_next = idx_dn;
            end
          end
          ACT_INSERT: begin
            if (slot_free) begin
              if (out_free) begin
                wr_en     = 1'b1;
                wr_data   = new_rec;
                res.found = 1'b1;
                res.slot  = cmp_idx;
                res.rec   = new_rec;
                done      = 1'b1;
              end
            end else if (last_up) begin
              if (out_free) begin
                if (count == CNT_W'(TABLE_DEPTH)) begin
                  res.full = 1'b1;
                end else begin
                  wr_en      = 1'b1;
                  wr_addr    = count[IDX_W-1:0];
                  wr_data    = new_rec;
                  count_next = count + CNT_W'(1);
                  res.found  = 1'b1;
                  res.slot   = count[IDX_W-1:0];
                  res.rec    = new_rec;
                end
                done = 1'b1;
              end
            end else begin
              rd_en        = 1'b1;
              rd_addr      = idx_up;
              cmp_idx_next = idx_up;
            end
          end
          ACT_PACK: begin
            // The write pointer never passes the read index, so the write
            // below cannot touch an entry that is still to be read.
            if (!last_up || out_free) begin
              if (!rdata.deleted) begin
                wr_en       = 1'b1;
                wr_addr     = wr_ptr[IDX_W-1:0];
                wr_data     = rdata;
                wr_ptr_next = wr_ptr + CNT_W'(1);
              end
              if (last_up) begin
                count_next = wr_ptr_next;
                done       = 1'b1;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = idx_up;
                cmp_idx_next = idx_up;
              end
            end
          end
          default: begin
            done = out_free;
          end
        endcase
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (done) state_next = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      found        <= res.found;
      slot         <= res.slot;
      out_key_text <= res.rec.text;
      out_key_mod  <= res.rec.kmod;
      out_payload  <= OUT_PAY_W'(res.rec.payload);
      out_deleted  <= res.rec.deleted;
      table_full   <= res.full;
      used_count   <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("used count exceeds the table depth");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !found && used_count == CNT_W'(TABLE_DEPTH))
    else $error("table full reported with a record or a free slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> {1'b0, slot} < used_count)
    else $error("reported slot lies above the used count");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state != ST_IDLE)
    else $error("memory write while idle");
`endif

endmodule
